FILE: src/acbmr_pkg.sv
// ----------------------------------------------------------------------------
// acbmr_pkg
// Shared constants for the per-channel mean removal block: field widths,
// slot map, register indexes and saturation limits.
// ----------------------------------------------------------------------------
package acbmr_pkg;

   localparam int CHANNELS_PER_CHIP = 8;
   localparam int CHIP_COUNT        = 2;
   localparam int SLOT_COUNT        = CHANNELS_PER_CHIP * CHIP_COUNT;
   localparam int SLOT_W            = $clog2(SLOT_COUNT);

   localparam int CHIP_W    = 1;
   localparam int CHANNEL_W = 3;
   localparam int SAMPLE_W  = 24;
   localparam int SUM_W     = 32;
   localparam int COUNT_W   = 7;
   localparam int SCALE_W   = 20;
   localparam int FRAC_W    = 16;
   localparam int SCALED_W  = 29;
   localparam int MEAN_W    = 24;

   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int PRODUCT_W  = DIFF_W + SCALE_W + 1;
   localparam int SHIFTED_W  = PRODUCT_W - FRAC_W;
   localparam int ENTRY_W    = SUM_W + COUNT_W;
   localparam int STEP_W     = $clog2(SUM_W);

   localparam int REQ_USER_W = CHIP_W + CHANNEL_W;
   localparam int REQ_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SCALED_W + MEAN_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = SCALE_W;

   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_FACTOR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SUB_CHIP0    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SUB_CHIP1    = 2'd3;

   localparam logic [COUNT_W-1:0] BLOCK_LENGTH_RESET = COUNT_W'(100);
   localparam logic [SCALE_W-1:0] SCALE_FACTOR_RESET = SCALE_W'(65536);

   localparam logic signed [SHIFTED_W-1:0] SAT_HI = SHIFTED_W'(2**(SCALED_W-1) - 1);
   localparam logic signed [SHIFTED_W-1:0] SAT_LO = SHIFTED_W'(-(2**(SCALED_W-1)));
   localparam logic [PRODUCT_W-1:0] ROUND_BIAS = PRODUCT_W'(2**FRAC_W - 1);

endpackage

FILE: src/acbmr_ram.sv
// ----------------------------------------------------------------------------
// acbmr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module acbmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/acbmr_divider.sv
// ----------------------------------------------------------------------------
// acbmr_divider
// Radix-2 restoring divider: signed sum over unsigned count, quotient
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acbmr_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [acbmr_pkg::SUM_W-1:0] dividend,
   input  logic [acbmr_pkg::COUNT_W-1:0]     divisor,
   output logic                              done,
   output logic signed [acbmr_pkg::SUM_W-1:0] quotient
);

   localparam logic [acbmr_pkg::STEP_W-1:0] LAST_STEP =
      acbmr_pkg::STEP_W'(acbmr_pkg::SUM_W - 1);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [acbmr_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [acbmr_pkg::SUM_W-1:0]        quo_ff, quo_in;
   logic [acbmr_pkg::COUNT_W-1:0]      rem_ff, rem_in;
   logic [acbmr_pkg::COUNT_W-1:0]      div_ff, div_in;
   logic                               neg_ff, neg_in;
   logic [acbmr_pkg::COUNT_W:0]        trial;
   logic                               fits;

   assign trial = {rem_ff, quo_ff[acbmr_pkg::SUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         div_in  = divisor;
         neg_in  = dividend[acbmr_pkg::SUM_W-1];
         // magnitude of the most negative sum still fits unsigned
         quo_in  = dividend[acbmr_pkg::SUM_W-1] ? -dividend : dividend;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = acbmr_pkg::COUNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[acbmr_pkg::COUNT_W-1:0];
         end
         quo_in  = {quo_ff[acbmr_pkg::SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

FILE: src/adc_channel_block_mean_removal.sv
// ----------------------------------------------------------------------------
// adc_channel_block_mean_removal
// Per-channel running mean over blocks of samples, optional mean removal
// and Q16 scaling with saturation.
// ----------------------------------------------------------------------------
// Flow: one item is in flight at a time; req_tready is high only while idle,
// and each item waits on the 32-step serial divider that forms the running
// mean before it is scaled and loaded into the output register.
// Reset: registers take their defaults and the per-slot valid bits clear,
// so every sum and count reads as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module adc_channel_block_mean_removal (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [acbmr_pkg::REQ_DATA_W-1:0]     req_tdata,  // raw_sample
   input  logic [acbmr_pkg::REQ_USER_W-1:0]     req_tuser,  // chip, channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [acbmr_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // scaled_value, running_mean
   output logic                                 rsp_tlast,  // block_end
   input  logic                                 csr_wr_en,
   input  logic [acbmr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [acbmr_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;

   logic [2:0] state_ff, state_in;

   // configuration
   logic [acbmr_pkg::COUNT_W-1:0] block_length_ff, block_length_in;
   logic [acbmr_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic                          sub0_ff, sub0_in;
   logic                          sub1_ff, sub1_in;

   // item context
   logic [acbmr_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [acbmr_pkg::CHIP_W-1:0]   chip_ff, chip_in;
   logic [acbmr_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                           unmapped_ff, unmapped_in;
   logic [acbmr_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                           end_ff, end_in;
   logic signed [acbmr_pkg::MEAN_W-1:0]    mean_ff, mean_in;
   logic signed [acbmr_pkg::PRODUCT_W-1:0] product_ff, product_in;

   logic [acbmr_pkg::SLOT_COUNT-1:0] valid_ff, valid_in;

   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [acbmr_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                           rsp_tlast_ff, rsp_tlast_in;

   // input decode
   logic [acbmr_pkg::CHIP_W-1:0]    req_chip;
   logic [acbmr_pkg::CHANNEL_W-1:0] req_channel;
   logic                            req_accept;

   // memory
   logic                            ram_wr_en;
   logic [acbmr_pkg::ENTRY_W-1:0]   ram_wr_data;
   logic [acbmr_pkg::ENTRY_W-1:0]   ram_rd_data;
   logic [acbmr_pkg::ENTRY_W-1:0]   entry;
   logic [acbmr_pkg::SUM_W-1:0]     new_sum;
   logic [acbmr_pkg::COUNT_W-1:0]   new_count;
   logic                            block_done;

   // divider
   logic                                div_start;
   logic                                div_done;
   logic signed [acbmr_pkg::SUM_W-1:0]  div_quotient;

   // scaling
   logic signed [acbmr_pkg::DIFF_W-1:0]     diff;
   logic signed [acbmr_pkg::SCALE_W:0]      scale_ext;
   logic                                    subtract;
   logic signed [acbmr_pkg::PRODUCT_W-1:0]  biased;
   logic signed [acbmr_pkg::SHIFTED_W-1:0]  shifted;
   logic signed [acbmr_pkg::SCALED_W-1:0]   scaled;
   logic                                    out_free;

   assign req_chip    = req_tuser[acbmr_pkg::CHIP_W-1:0];
   assign req_channel = req_tuser[acbmr_pkg::REQ_USER_W-1:acbmr_pkg::CHIP_W];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign out_free    = !rsp_tvalid_ff || rsp_tready;

   // entries never written since reset read as zero
   assign entry      = valid_ff[slot_ff] ? ram_rd_data : '0;
   assign new_sum    = entry[acbmr_pkg::ENTRY_W-1:acbmr_pkg::COUNT_W]
                       + {{(acbmr_pkg::SUM_W - acbmr_pkg::SAMPLE_W){sample_ff[acbmr_pkg::SAMPLE_W-1]}},
                          sample_ff};
   assign new_count  = entry[acbmr_pkg::COUNT_W-1:0] + 1'b1;
   assign block_done = (new_count >= block_length_ff) || (new_count == '0);

   assign ram_wr_en   = (state_ff == ST_READ) && !unmapped_ff;
   assign ram_wr_data = block_done ? '0 : {new_sum, new_count};
   assign div_start   = (state_ff == ST_READ);

   assign subtract  = (chip_ff == '0) ? sub0_ff : sub1_ff;
   assign diff      = subtract ? ($signed({sample_ff[acbmr_pkg::SAMPLE_W-1], sample_ff})
                                  - $signed({mean_ff[acbmr_pkg::MEAN_W-1], mean_ff}))
                               : $signed({sample_ff[acbmr_pkg::SAMPLE_W-1], sample_ff});
   assign scale_ext = $signed({1'b0, scale_ff});

   // truncate toward zero: bias negatives before the arithmetic shift
   assign biased  = product_ff + (product_ff[acbmr_pkg::PRODUCT_W-1]
                                  ? $signed(acbmr_pkg::ROUND_BIAS) : '0);
   assign shifted = biased[acbmr_pkg::PRODUCT_W-1:acbmr_pkg::FRAC_W];

   always_comb begin
      if (shifted > acbmr_pkg::SAT_HI) begin
         scaled = acbmr_pkg::SAT_HI[acbmr_pkg::SCALED_W-1:0];
      end else if (shifted < acbmr_pkg::SAT_LO) begin
         scaled = acbmr_pkg::SAT_LO[acbmr_pkg::SCALED_W-1:0];
      end else begin
         scaled = shifted[acbmr_pkg::SCALED_W-1:0];
      end
   end

   always_comb begin
      block_length_in = block_length_ff;
      scale_in        = scale_ff;
      sub0_in         = sub0_ff;
      sub1_in         = sub1_ff;
      if (csr_wr_en) begin
         case (csr_index)
            acbmr_pkg::REG_BLOCK_LENGTH: block_length_in = csr_wr_data[acbmr_pkg::COUNT_W-1:0];
            acbmr_pkg::REG_SCALE_FACTOR: scale_in        = csr_wr_data[acbmr_pkg::SCALE_W-1:0];
            acbmr_pkg::REG_SUB_CHIP0:    sub0_in         = csr_wr_data[0];
            acbmr_pkg::REG_SUB_CHIP1:    sub1_in         = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      chip_in       = chip_ff;
      slot_in       = slot_ff;
      unmapped_in   = unmapped_ff;
      count_in      = count_ff;
      end_in        = end_ff;
      mean_in       = mean_ff;
      product_in    = product_ff;
      valid_in      = valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sample_in   = req_tdata[acbmr_pkg::SAMPLE_W-1:0];
               chip_in     = req_chip;
               slot_in     = acbmr_pkg::SLOT_W'(int'(req_chip) * acbmr_pkg::CHANNELS_PER_CHIP
                                                + int'(req_channel));
               unmapped_in = (int'(req_chip) >= acbmr_pkg::CHIP_COUNT)
                             || (int'(req_channel) >= acbmr_pkg::CHANNELS_PER_CHIP);
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            count_in = new_count;
            end_in   = block_done && !unmapped_ff;
            if (!unmapped_ff) begin
               valid_in[slot_ff] = 1'b1;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in  = (count_ff == '0) ? '0 : div_quotient[acbmr_pkg::MEAN_W-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            product_in = diff * scale_ext;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               if (unmapped_ff) begin
                  rsp_tdata_in = '0;
               end else begin
                  rsp_tdata_in = acbmr_pkg::RSP_DATA_W'({mean_ff, scaled});
               end
               rsp_tlast_in = end_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         block_length_ff <= acbmr_pkg::BLOCK_LENGTH_RESET;
         scale_ff        <= acbmr_pkg::SCALE_FACTOR_RESET;
         sub0_ff         <= 1'b0;
         sub1_ff         <= 1'b1;
         valid_ff        <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         block_length_ff <= block_length_in;
         scale_ff        <= scale_in;
         sub0_ff         <= sub0_in;
         sub1_ff         <= sub1_in;
         valid_ff        <= valid_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
      sample_ff    <= sample_in;
      chip_ff      <= chip_in;
      slot_ff      <= slot_in;
      unmapped_ff  <= unmapped_in;
      count_ff     <= count_in;
      end_ff       <= end_in;
      mean_ff      <= mean_in;
      product_ff   <= product_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   acbmr_ram #(
      .WIDTH (acbmr_pkg::ENTRY_W),
      .DEPTH (acbmr_pkg::SLOT_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (slot_in),
      .rd_data (ram_rd_data)
   );

   acbmr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ($signed(new_sum)),
      .divisor  (new_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_READ)
      else $error("accepted transaction did not move to the read cycle");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide phase");

   a_write_mapped: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_READ) && !unmapped_ff)
      else $error("state write outside the read cycle or for an unmapped tag");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) && !out_free |=> state_ff == ST_SCALE)
      else $error("result dropped while the output register was full");

endmodule
